### sv/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, register addresses, status codes and controller states for
// the Newton-Raphson square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int SQ_W    = 2 * DATA_W;
    localparam int DEN_W   = DATA_W + 1;
    localparam int RESID_W = 49;
    localparam int TOL_W   = 16;
    localparam int CNT_W   = 8;
    localparam int ADDR_W  = 4;

    // Register byte addresses on the configuration port.
    localparam logic [ADDR_W-1:0] ADDR_GUESS = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_TOL   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_LIMIT = 4'h8;

    // Register values after reset.
    localparam logic [DATA_W-1:0] GUESS_RESET = 32'd6554;
    localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd1;
    localparam logic [CNT_W-1:0]  LIMIT_RESET = 8'd32;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_CONVERGED = 2'd0,
        STATUS_LIMIT     = 2'd1,
        STATUS_ZERO_DERIV = 2'd2
    } status_t;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQ   = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_UPD  = 6'b001000,
        ST_RSQ  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

### sv/nsr_sqr.sv
// ----------------------------------------------------------------------------
// nsr_sqr
// Bit-serial squarer: one multiplier bit is consumed per cycle by shift and
// add, giving the full 64-bit square.
// ----------------------------------------------------------------------------
module nsr_sqr
    import nsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] operand,
    output logic              done,
    output logic [SQ_W-1:0]   square
);

    localparam int CW = $clog2(DATA_W);
    localparam logic [CW-1:0] LAST = CW'(DATA_W - 1);

    logic [DATA_W-1:0] mcand_reg;
    logic [SQ_W-1:0]   prod_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W:0]   sum;

    // Add the multiplicand to the upper half when the current bit is set.
    always_comb
    begin
        sum = {1'b0, prod_reg[SQ_W-1:DATA_W]}
            + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    end

    // Control: counter, busy and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the partial product right one bit a cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= operand;
            prod_reg  <= {{DATA_W{1'b0}}, operand};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[DATA_W-1:1]};
        end
    end

    assign done   = done_reg;
    assign square = prod_reg;

endmodule

### sv/nsr_div.sv
// ----------------------------------------------------------------------------
// nsr_div
// Restoring divider: one quotient bit per cycle for a 64-bit dividend over
// a 33-bit divisor, truncating toward zero.
// ----------------------------------------------------------------------------
module nsr_div
    import nsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQ_W-1:0]  dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [SQ_W-1:0]  quotient
);

    localparam int CW = $clog2(SQ_W);
    localparam logic [CW-1:0] LAST = CW'(SQ_W - 1);

    logic [DEN_W-1:0] dvsr_reg;
    logic [SQ_W-1:0]  quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, quo_reg[SQ_W-1]};
        fits  = trial >= {1'b0, dvsr_reg};
        diff  = trial - {1'b0, dvsr_reg};
    end

    // Control: counter, busy and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvsr_reg <= divisor;
            quo_reg  <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[SQ_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/newton_square_root_core.sv
// ----------------------------------------------------------------------------
// newton_square_root_core
// Newton-Raphson square root of an unsigned Q16.16 radicand.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, radicand) takes one radicand per
//   transfer. The output channel (out_valid, out_stall) returns one result per
//   radicand: root_value, residual (root squared minus radicand, Q32.16),
//   step_count and status (converged, iteration limit, zero derivative).
//   Each Newton step runs the bit-serial squarer, then the restoring divider,
//   then a control update. After the last step the root is squared once more
//   for the residual; a zero initial guess goes straight to that final square.
//   One item is worked on at a time; in_stall is high while it is in work.
//   A finished result waits in the output register while the receiver stalls;
//   the next radicand is accepted meanwhile, and its result is held back
//   until the previous one has been transferred.
//   Reset restores initial_guess 0.1, tolerance 1 LSB and limit 32, and
//   empties the block. Registers are to be written over the APB port only
//   while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module newton_square_root_core
    import nsr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // Input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [DATA_W-1:0]         radicand,
    // Output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DATA_W-1:0]         root_value,
    output logic signed [RESID_W-1:0] residual,
    output logic [CNT_W-1:0]          step_count,
    output logic [1:0]                status
);

    // Configuration registers.
    logic [DATA_W-1:0] guess_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [CNT_W-1:0]  limit_reg;

    // Controller and working registers.
    state_t            state_reg;
    logic [DATA_W-1:0] n_reg;
    logic [DATA_W-1:0] x0_reg;
    logic [DATA_W-1:0] x1_reg;
    logic [CNT_W-1:0]  k_reg;
    status_t           stat_reg;
    logic              ge_reg;
    logic [SQ_W-1:0]   num_reg;
    logic              sq_start_reg;
    logic [DATA_W-1:0] sq_op_reg;
    logic              div_start_reg;
    logic signed [RESID_W-1:0] resid_work_reg;

    // Output registers.
    logic                      out_valid_reg;
    logic [DATA_W-1:0]         root_reg;
    logic signed [RESID_W-1:0] resid_reg;
    logic [CNT_W-1:0]          cnt_out_reg;
    logic [1:0]                stat_out_reg;

    logic              sq_done;
    logic [SQ_W-1:0]   square;
    logic              div_done;
    logic [SQ_W-1:0]   quotient;
    logic              wr_en;
    logic              in_take;
    logic              out_free;
    logic [SQ_W-1:0]   nn;
    logic [DATA_W:0]   up_sum;
    logic [DATA_W-1:0] x_next;
    logic [DATA_W-1:0] step_mag;
    logic [RESID_W-1:0] resid_raw;

    nsr_sqr u_sqr (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start_reg),
        .operand (sq_op_reg),
        .done    (sq_done),
        .square  (square)
    );

    nsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (num_reg),
        .divisor  ({x0_reg, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    // Configuration write and read back.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guess_reg <= GUESS_RESET;
            tol_reg   <= TOL_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr == ADDR_GUESS)
            begin
                guess_reg <= pwdata;
            end
            if (paddr == ADDR_TOL)
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
            if (paddr == ADDR_LIMIT)
            begin
                limit_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        priority if (paddr == ADDR_GUESS)
        begin
            prdata = guess_reg;
        end
        else if (paddr == ADDR_TOL)
        begin
            prdata = {{(32 - TOL_W){1'b0}}, tol_reg};
        end
        else if (paddr == ADDR_LIMIT)
        begin
            prdata = {{(32 - CNT_W){1'b0}}, limit_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Handshake terms.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Step arithmetic: aligned radicand, the updated estimate, step size and the raw residual.
    always_comb
    begin
        nn     = {{FRAC_W{1'b0}}, n_reg, {FRAC_W{1'b0}}};
        up_sum = {1'b0, x0_reg} + {1'b0, quotient[DATA_W-1:0]};
        if (ge_reg)
        begin
            x_next = x0_reg - quotient[DATA_W-1:0];
        end
        else if ((|quotient[SQ_W-1:DATA_W]) || up_sum[DATA_W])
        begin
            x_next = '1;
        end
        else
        begin
            x_next = up_sum[DATA_W-1:0];
        end
        step_mag  = (x1_reg >= x0_reg) ? (x1_reg - x0_reg) : (x0_reg - x1_reg);
        resid_raw = {1'b0, square[SQ_W-1:FRAC_W]}
                  - {{(RESID_W - DATA_W){1'b0}}, n_reg};
    end

    // Start pulses for the squarer and divider, and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_start_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sq_start_reg  <= ((state_reg == ST_IDLE) && in_take) || (state_reg == ST_UPD);
            div_start_reg <= (state_reg == ST_SQ) && sq_done;
            out_valid_reg <= ((state_reg == ST_DONE) && out_free)
                          || (out_valid_reg && out_stall);
        end
    end

    // Controller.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= (guess_reg == '0) ? ST_RSQ : ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    if ((step_mag <= {{(DATA_W - TOL_W){1'b0}}, tol_reg})
                        || (k_reg >= limit_reg))
                    begin
                        state_reg <= ST_RSQ;
                    end
                    else
                    begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_RSQ:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    n_reg     <= radicand;
                    x0_reg    <= guess_reg;
                    x1_reg    <= '0;
                    k_reg     <= CNT_W'(1);
                    sq_op_reg <= guess_reg;
                    stat_reg  <= (guess_reg == '0) ? STATUS_ZERO_DERIV
                                                   : STATUS_CONVERGED;
                end
            end
            ST_SQ:
            begin
                if (sq_done)
                begin
                    ge_reg  <= square >= nn;
                    num_reg <= (square >= nn) ? (square - nn) : (nn - square);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    x1_reg <= x_next;
                end
            end
            ST_UPD:
            begin
                sq_op_reg <= x1_reg;
                if (step_mag > {{(DATA_W - TOL_W){1'b0}}, tol_reg})
                begin
                    if (k_reg >= limit_reg)
                    begin
                        stat_reg <= STATUS_LIMIT;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 1'b1;
                        x0_reg <= x1_reg;
                    end
                end
            end
            ST_RSQ, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result register, loaded once the previous result has been transferred.
    // The residual is kept aside until then so that a waiting result holds.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RSQ && sq_done)
        begin
            resid_work_reg <= $signed(resid_raw);
        end
        if (state_reg == ST_DONE && out_free)
        begin
            root_reg     <= x1_reg;
            resid_reg    <= resid_work_reg;
            cnt_out_reg  <= k_reg;
            stat_out_reg <= stat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root_value = root_reg;
    assign residual   = resid_reg;
    assign step_count = cnt_out_reg;
    assign status     = stat_out_reg;

endmodule

### bench/tb_newton_square_root_core.sv
// ----------------------------------------------------------------------------
// tb_newton_square_root_core
// Self-checking bench for the Newton-Raphson square root core. A queue of
// radicands feeds a clocked driver. A local model of the fixed-point
// iteration predicts each result when its input transfer happens. A clocked
// monitor compares every output transfer, field by field, with the oldest
// prediction. The configuration registers are rewritten over APB between
// phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_newton_square_root_core
    import nsr_pkg::*;
;

    localparam logic [63:0] DATA_MASK   = 64'h0000_0000_FFFF_FFFF;
    localparam int          WATCH_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [DATA_W-1:0]  root;
        logic [RESID_W-1:0] resid;
        logic [CNT_W-1:0]   steps;
        status_t            stat;
    } root_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [DATA_W-1:0]         radicand = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [DATA_W-1:0]         root_value;
    logic signed [RESID_W-1:0] residual;
    logic [CNT_W-1:0]          step_count;
    logic [1:0]                status;

    // Register copies used by the prediction.
    logic [DATA_W-1:0] cfg_guess = GUESS_RESET;
    logic [TOL_W-1:0]  cfg_tol   = TOL_RESET;
    logic [CNT_W-1:0]  cfg_limit = LIMIT_RESET;

    logic [DATA_W-1:0] radicand_queue[$];
    root_result_t      expected_roots[$];
    int                driven_cnt = 0;
    int                accepted_cnt = 0;
    int                fail_cnt = 0;
    int                send_idle_pct = 7;
    int                recv_idle_pct = 51;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    int                quiet_cycles = 0;

    newton_square_root_core dut (.*);

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One Newton update with saturation at the all-ones value.
    function automatic logic [63:0] newton_update(input logic [63:0] x, input logic [63:0] n);
        logic [63:0] sq;
        logic [63:0] nn;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] nxt;
        sq  = x * x;
        nn  = n << FRAC_W;
        den = x << 1;
        if (sq >= nn)
            nxt = x - (sq - nn) / den;
        else
        begin
            q   = (nn - sq) / den;
            nxt = x + q;
            if (q > DATA_MASK || nxt > DATA_MASK || nxt < x)
                nxt = DATA_MASK;
        end
        return nxt & DATA_MASK;
    endfunction

    function automatic logic [63:0] distance(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Full iteration for one radicand under the current register copies.
    function automatic root_result_t solve_root(input logic [DATA_W-1:0] n);
        root_result_t     r;
        logic [63:0]      x0;
        logic [63:0]      x1;
        logic signed [63:0] diff;
        int               k;
        status_t          st;
        x0 = {32'b0, cfg_guess};
        k  = 1;
        st = STATUS_CONVERGED;
        if (x0 == 0)
        begin
            x1 = 0;
            st = STATUS_ZERO_DERIV;
        end
        else
        begin
            x1 = newton_update(x0, {32'b0, n});
            while (distance(x1, x0) > {48'b0, cfg_tol})
            begin
                if (k >= cfg_limit)
                begin
                    st = STATUS_LIMIT;
                    break;
                end
                k++;
                x0 = x1;
                x1 = newton_update(x0, {32'b0, n});
            end
        end
        diff    = $signed((x1 * x1) >> FRAC_W) - $signed({32'b0, n});
        r.root  = x1[DATA_W-1:0];
        r.resid = diff[RESID_W-1:0];
        r.steps = k[CNT_W-1:0];
        r.stat  = st;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
        fail_cnt++;
    endtask

    // Input driver: a new radicand is offered once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n && driven_cnt == accepted_cnt)
        begin
            if (radicand_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                radicand   <= radicand_queue.pop_front();
                in_valid   <= 1'b1;
                driven_cnt <= driven_cnt + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with one long hold-off early in the run.
    always @(negedge clk)
    begin
        if (!hold_done && accepted_cnt >= 30)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Input transfers: predict the result.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_roots.push_back(solve_root(radicand));
            accepted_cnt++;
        end
    end

    // Output transfers: compare with the oldest prediction.
    always @(posedge clk)
    begin
        root_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("result transfer with no radicand outstanding");
                fail_cnt++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root_value !== want.root)
                    report_mismatch("root_value", root_value, want.root);
                if (residual !== want.resid)
                    report_mismatch("residual", residual, want.resid);
                if (step_count !== want.steps)
                    report_mismatch("step_count", step_count, want.steps);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("newton_square_root_core test failed");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_GUESS: cfg_guess = data[DATA_W-1:0];
            ADDR_TOL:   cfg_tol   = data[TOL_W-1:0];
            ADDR_LIMIT: cfg_limit = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] guess, input logic [31:0] tol,
                            input logic [31:0] limit);
        write_reg(ADDR_GUESS, guess);
        write_reg(ADDR_TOL, tol);
        write_reg(ADDR_LIMIT, limit);
    endtask

    // Queue random radicands: a quarter small, the rest over the full range.
    task automatic queue_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(3) == 0)
                radicand_queue.push_back($urandom_range(32'hFFFF));
            else
                radicand_queue.push_back($urandom);
        end
    endtask

    // Block until every queued radicand has been answered.
    task automatic drain();
        while (radicand_queue.size() > 0 || driven_cnt != accepted_cnt ||
               expected_roots.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Stimulus phases.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: field extremes and a few exact squares.
        radicand_queue = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0004_0000,
                           32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_4000,
                           32'h0090_0000, 32'h7FFF_FFFF, 32'h0000_FFFF};
        queue_random(150);
        drain();

        // Zero initial guess gives the zero-derivative flag.
        set_regs(32'h0, 32'd1, 32'd32);
        radicand_queue = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
        queue_random(7);
        drain();

        // Zero tolerance and the largest limit: may run to the limit.
        set_regs(32'h0001_0000, 32'd0, 32'd255);
        radicand_queue = '{32'h0, 32'hFFFF_FFFF, 32'h0002_0000};
        queue_random(3);
        drain();

        // Largest guess, largest tolerance, a limit of one.
        set_regs(32'hFFFF_FFFF, 32'd65535, 32'd1);
        queue_random(100);
        drain();

        // Smallest guess; oversized writes, the limit truncating to zero.
        set_regs(32'h1, 32'hABCD_0003, 32'hFFFF_FF00);
        radicand_queue = '{32'h0, 32'hFFFF_FFFF};
        queue_random(100);
        drain();

        // Swap the idling: sender idles more than the receiver.
        send_idle_pct = 51;
        recv_idle_pct = 7;
        set_regs(32'h0001_0000, 32'd4, 32'd20);
        queue_random(350);
        drain();

        // Random settings, no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5)
        begin
            set_regs($urandom, $urandom_range(64), $urandom_range(1, 24));
            queue_random(70);
            drain();
        end

        repeat (200) @(posedge clk);
        if (fail_cnt == 0 && expected_roots.size() == 0)
            $display("newton_square_root_core test passed");
        else
            $display("newton_square_root_core test failed");
        $finish;
    end

endmodule
